[hw/rtl/ntclin_pkg.sv]
// ntclin_pkg: shared types, constants and the breakpoint table for the
// ntc temperature linearizer. No dependencies.

package ntclin_pkg;

	localparam int ADC_W         = 18;
	localparam int TEMP_W        = 15;
	localparam int TABLE_ENTRIES = 39;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int BP16_W        = 21;
	localparam int QUO_W         = 9;
	localparam int BIT_W         = $clog2(QUO_W);
	localparam int T_FIRST_CENTI = -4000;
	localparam int T_STEP_CENTI  = 500;
	localparam int T_LAST_CENTI  = T_FIRST_CENTI + T_STEP_CENTI * (TABLE_ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_SEARCH,
		ST_OFFSET,
		ST_WIDTH,
		ST_SCALE,
		ST_DIV,
		ST_FIN
	} state_t;

	// divider voltage per breakpoint, in converter lsb times 16
	function automatic logic [BP16_W-1:0] bp16(input logic [IDX_W-1:0] i);
		logic [BP16_W-1:0] v;
		case (i)
			6'd0:    v = 21'd1849;
			6'd1:    v = 21'd2560;
			6'd2:    v = 21'd3504;
			6'd3:    v = 21'd4748;
			6'd4:    v = 21'd6368;
			6'd5:    v = 21'd8460;
			6'd6:    v = 21'd11137;
			6'd7:    v = 21'd14533;
			6'd8:    v = 21'd18804;
			6'd9:    v = 21'd24133;
			6'd10:   v = 21'd30732;
			6'd11:   v = 21'd38841;
			6'd12:   v = 21'd48731;
			6'd13:   v = 21'd60712;
			6'd14:   v = 21'd75120;
			6'd15:   v = 21'd92322;
			6'd16:   v = 21'd112734;
			6'd17:   v = 21'd136777;
			6'd18:   v = 21'd164940;
			6'd19:   v = 21'd197620;
			6'd20:   v = 21'd235402;
			6'd21:   v = 21'd278766;
			6'd22:   v = 21'd328030;
			6'd23:   v = 21'd383760;
			6'd24:   v = 21'd446512;
			6'd25:   v = 21'd516303;
			6'd26:   v = 21'd593355;
			6'd27:   v = 21'd678146;
			6'd28:   v = 21'd770601;
			6'd29:   v = 21'd870625;
			6'd30:   v = 21'd977877;
			6'd31:   v = 21'd1092065;
			6'd32:   v = 21'd1212791;
			6'd33:   v = 21'd1339437;
			6'd34:   v = 21'd1470913;
			6'd35:   v = 21'd1606695;
			6'd36:   v = 21'd1745951;
			6'd37:   v = 21'd1887558;
			6'd38:   v = 21'd2030404;
			default: v = '0;
		endcase
		return v;
	endfunction

	// temperature at the start of segment i, in 0.01 C
	function automatic logic signed [TEMP_W-1:0] temp_at(input logic [IDX_W-1:0] i);
		return TEMP_W'(T_FIRST_CENTI + T_STEP_CENTI * int'(i));
	endfunction

endpackage

[hw/rtl/ntclin_in_if.sv]
// ntclin_in_if: valid/ready channel carrying one converter sample.
// Depends on ntclin_pkg.

interface ntclin_in_if;
	import ntclin_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ADC_W-1:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink (input valid, input adc_code, output ready);
endinterface

[hw/rtl/ntclin_out_if.sv]
// ntclin_out_if: valid/ready channel carrying one temperature result.
// Depends on ntclin_pkg.

interface ntclin_out_if;
	import ntclin_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_centi;
	logic                     clamped_low;
	logic                     clamped_high;

	modport source (output valid, output temp_centi, output clamped_low,
		output clamped_high, input ready);
	modport sink (input valid, input temp_centi, input clamped_low,
		input clamped_high, output ready);
endinterface

[hw/rtl/ntclin_alu.sv]
// ntclin_alu: shared signed subtractor with greater-or-equal flag, used for
// the clamp checks, the segment search, the offset and width and the divide steps.
// No dependencies.

module ntclin_alu #(
	parameter int W = 32
) (
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] diff,
	output logic                ge
);
	assign diff = a - b;
	assign ge   = ~diff[W-1];
endmodule

[hw/rtl/ntc_temperature_linearizer.sv]
// ntc_temperature_linearizer: one sample in, one temperature out.
// A clamped sample goes from the low check (or the high check) straight to the result
// register; an interpolated one first runs a linear segment search of up to 38 steps plus
// a 9-step restoring divide, all through one shared subtractor. A new sample is taken
// once the last result is loaded; the result register frees the input side early.
// Reset: arst_n clears the sequencer and the result valid flag at once.

module ntc_temperature_linearizer #(
	parameter int FRAC_BITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	ntclin_in_if.sink         sample,
	ntclin_out_if.source      result
);
	import ntclin_pkg::*;

	localparam int XW   = ADC_W + FRAC_BITS;
	localparam int AW   = XW + 10;
	localparam int BW   = XW + 4;
	localparam int UP   = (FRAC_BITS >= 4) ? FRAC_BITS - 4 : 0;
	localparam int DN   = (FRAC_BITS >= 4) ? 0 : 4 - FRAC_BITS;
	localparam int HALF = (DN == 0) ? 0 : (1 << (DN - 1));

	// breakpoint i at scale 2^FRAC_BITS, half-up rounding when scaled down
	function automatic logic [XW-1:0] bp_at(input logic [IDX_W-1:0] i);
		logic [BW-1:0] b;
		b = BW'(bp16(i)) << UP;
		b = (b + BW'(HALF)) >> DN;
		return b[XW-1:0];
	endfunction

	state_t state_q, state_d;

	logic signed [XW-1:0]     x_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         seg;
	logic [XW-1:0]            off_q;
	logic [XW-1:0]            wid_q;
	logic signed [AW-1:0]     rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [BIT_W-1:0]         bit_q;
	logic                     lo_q, hi_q;
	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     out_lo_q, out_hi_q;
	logic signed [TEMP_W-1:0] temp_fin;
	logic                     load_out;

	logic signed [AW-1:0] alu_a, alu_b, alu_diff;
	logic                 alu_ge;

	ntclin_alu #(.W(AW)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assign seg = idx_q - IDX_W'(1);

	always_comb begin
		if (lo_q) begin
			temp_fin = TEMP_W'(T_FIRST_CENTI);
		end else if (hi_q) begin
			temp_fin = TEMP_W'(T_LAST_CENTI);
		end else begin
			temp_fin = temp_at(seg) + signed'(TEMP_W'(quo_q));
		end
	end

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// operand select for the shared subtractor
	always_comb begin
		alu_a = AW'(x_q);
		alu_b = signed'(AW'(bp_at(idx_q)));
		case (state_q)
			ST_CHK_LO: begin
				alu_a = signed'(AW'(bp_at('0)));
				alu_b = AW'(x_q);
			end
			ST_CHK_HI: begin
				alu_b = signed'(AW'(bp_at(IDX_W'(TABLE_ENTRIES - 1))));
			end
			ST_OFFSET: begin
				alu_b = signed'(AW'(bp_at(seg)));
			end
			ST_WIDTH: begin
				alu_a = signed'(AW'(bp_at(idx_q)));
				alu_b = signed'(AW'(bp_at(seg)));
			end
			ST_DIV: begin
				alu_a = rem_q;
				alu_b = signed'(AW'(wid_q) << bit_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (sample.valid) state_d = ST_CHK_LO;
			ST_CHK_LO: state_d = alu_ge ? ST_FIN : ST_CHK_HI;
			ST_CHK_HI: state_d = alu_ge ? ST_FIN : ST_SEARCH;
			ST_SEARCH: if (!alu_ge) state_d = ST_OFFSET;
			ST_OFFSET: state_d = ST_WIDTH;
			ST_WIDTH:  state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_DIV;
			ST_DIV:    if (bit_q == '0) state_d = ST_FIN;
			ST_FIN:    if (load_out) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= XW'(sample.adc_code) <<< FRAC_BITS;
				lo_q  <= 1'b0;
				hi_q  <= 1'b0;
				idx_q <= IDX_W'(1);
			end
			ST_CHK_LO: lo_q <= alu_ge;
			ST_CHK_HI: hi_q <= alu_ge;
			ST_SEARCH: if (alu_ge) idx_q <= idx_q + IDX_W'(1);
			ST_OFFSET: off_q <= alu_diff[XW-1:0];
			ST_WIDTH:  wid_q <= alu_diff[XW-1:0];
			ST_SCALE: begin
				rem_q <= signed'(AW'(off_q) * AW'(T_STEP_CENTI));
				quo_q <= '0;
				bit_q <= BIT_W'(QUO_W - 1);
			end
			ST_DIV: begin
				if (alu_ge) begin
					rem_q        <= alu_diff;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - BIT_W'(1);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			temp_q   <= temp_fin;
			out_lo_q <= lo_q;
			out_hi_q <= hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample.ready        = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.temp_centi   = temp_q;
	assign result.clamped_low  = out_lo_q;
	assign result.clamped_high = out_hi_q;

	// both clamp flags never on the same result
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.clamped_low && result.clamped_high))
		else $error("both clamp flags set");

	// a low clamp always reports the first breakpoint temperature
	a_lo_temp: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clamped_low |-> result.temp_centi == TEMP_W'(T_FIRST_CENTI))
		else $error("low clamp with wrong temperature");

	// search never runs past the last breakpoint
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> idx_q <= IDX_W'(TABLE_ENTRIES - 1))
		else $error("segment search out of range");

	// results stay within the table temperature span
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.temp_centi >= TEMP_W'(T_FIRST_CENTI)
			&& result.temp_centi <= TEMP_W'(T_LAST_CENTI))
		else $error("temperature out of range");

endmodule
